// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the route table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define KR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define KR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/kr_pkg.sv =====
`timescale 1ns / 1ps

package kr_pkg;

  // Table geometry.
  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned KEY_W       = 32;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUTE_TYPE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT = 1'b1;

  // Command codes.
  localparam logic [2:0] CMD_ADD      = 3'd0;
  localparam logic [2:0] CMD_REMOVE   = 3'd1;
  localparam logic [2:0] CMD_REKEY    = 3'd2;
  localparam logic [2:0] CMD_LOOKUP   = 3'd3;
  localparam logic [2:0] CMD_SHORTEST = 3'd4;
  localparam logic [2:0] CMD_BY_POS   = 3'd5;
  localparam logic [2:0] CMD_BY_ID    = 3'd6;
  localparam logic [2:0] CMD_SET_QLEN = 3'd7;

  // Status codes.
  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_NONE = 3'd1;
  localparam logic [2:0] ST_ZERO = 3'd2;
  localparam logic [2:0] ST_TYPE = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;

  typedef struct packed {
    logic [2:0]       command;
    logic [KEY_W-1:0] key;
    logic [15:0]      dest_id;
    logic [15:0]      dest_type;
    logic             dest_remote;
    logic [15:0]      queue_length;
    logic [5:0]       position;
  } kr_in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [15:0]      found_id;
    logic [15:0]      found_type;
    logic             found_remote;
    logic [KEY_W-1:0] found_end_key;
    logic [5:0]       found_position;
    logic [6:0]       entry_total;
  } kr_out_t;

  // One table entry as held in the memory.
  typedef struct packed {
    logic [KEY_W-1:0] end_key;
    logic [15:0]      id;
    logic [15:0]      dtype;
    logic             remote;
    logic [15:0]      qlen;
  } kr_entry_t;

endpackage

// ===== rtl/kr_ram.sv =====
`timescale 1ns / 1ps

module kr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/kr_div.sv =====
`timescale 1ns / 1ps

module kr_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [kr_pkg::KEY_W-1:0] dividend_i,
  input  logic [kr_pkg::KEY_W-1:0] divisor_i,
  output logic                     done_o,
  output logic [kr_pkg::KEY_W-1:0] rem_o
);
  import kr_pkg::*;

  localparam int unsigned STEP_W = $clog2(KEY_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [KEY_W:0]    rem_q, rem_d;
  logic [KEY_W-1:0]  quo_q, quo_d;
  logic [KEY_W-1:0]  div_q, div_d;
  logic [KEY_W:0]    shifted;
  logic [KEY_W+1:0]  diff;

  // Restoring division, one quotient bit per cycle; only the remainder is kept.
  always_comb begin
    shifted = {rem_q[KEY_W-1:0], quo_q[KEY_W-1]};
    diff    = {1'b0, shifted} - {2'b00, div_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    step_d  = step_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    div_d   = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(KEY_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q) begin
      quo_d  = {quo_q[KEY_W-2:0], 1'b0};
      rem_d  = diff[KEY_W+1] ? shifted : diff[KEY_W:0];
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[KEY_W-1:0];

endmodule

// ===== rtl/keyed_range_route_table.sv =====
`timescale 1ns / 1ps

// Route table of up to 64 destinations kept sorted by range end in a
// single-port-write, registered-read memory; a sequencer walks it one entry
// per cycle and takes one transaction at a time. Key lookup and shortest
// queue both use the shared bit-serial divider that forms the key
// remainders. The next transaction can be taken once the result has moved
// into the output register. Results leave through an output register, so a
// finished result may wait there while the next transaction is taken. No
// clearing pass follows reset.
module keyed_range_route_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  kr_pkg::kr_in_t                in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output kr_pkg::kr_out_t               out_data_o,
  input  logic                          cfg_we_i,
  input  logic [kr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [kr_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import kr_pkg::*;

  `include "assert_macros.svh"

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_FIND    = 4'd1;
  localparam logic [3:0] S_SHIFT   = 4'd2;
  localparam logic [3:0] S_INS_CHK = 4'd3;
  localparam logic [3:0] S_INS     = 4'd4;
  localparam logic [3:0] S_LAST    = 4'd5;
  localparam logic [3:0] S_DIV     = 4'd6;
  localparam logic [3:0] S_SCAN    = 4'd7;
  localparam logic [3:0] S_SQ1     = 4'd8;
  localparam logic [3:0] S_SQ2     = 4'd9;
  localparam logic [3:0] S_POS     = 4'd10;
  localparam logic [3:0] S_FIN     = 4'd11;

  localparam int unsigned ENT_W = $bits(kr_entry_t);

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [15:0]      active_q, active_d;
  logic [15:0]      qlimit_q, qlimit_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             chk_v_q, chk_v_d;
  logic [IDX_W-1:0] chk_idx_q, chk_idx_d;
  logic             out_valid_q, out_valid_d;
  kr_in_t           req_q, req_d;
  kr_entry_t        ent_q, ent_d;
  logic [KEY_W-1:0] val_q, val_d;
  logic [15:0]      best_q, best_d;
  logic [CNT_W-1:0] ties_q, ties_d;
  logic [CNT_W-1:0] seen_q, seen_d;
  logic [CNT_W-1:0] pick_q, pick_d;
  kr_out_t          res_q, res_d;
  kr_out_t          out_q, out_d;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  kr_entry_t        ram_wdata, rdata;
  logic [ENT_W-1:0] ram_rdata;

  logic             div_start, div_done;
  logic [KEY_W-1:0] div_divisor, div_rem;
  logic [15:0]      eff_type;

  function automatic kr_out_t res_ok(kr_entry_t e, logic [IDX_W-1:0] p,
                                     logic [CNT_W-1:0] total);
    kr_out_t r;
    r.status          = ST_OK;
    r.found_id        = e.id;
    r.found_type      = e.dtype;
    r.found_remote    = e.remote;
    r.found_end_key   = e.end_key;
    r.found_position  = p;
    r.entry_total     = total;
    return r;
  endfunction

  function automatic kr_out_t res_err(logic [2:0] st, logic [CNT_W-1:0] total);
    kr_out_t r;
    r             = '0;
    r.status      = st;
    r.entry_total = total;
    return r;
  endfunction

  kr_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rdata = kr_entry_t'(ram_rdata);

  kr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (req_q.key),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign eff_type = (active_q == '0) ? ent_q.dtype : active_q;

  // Sequencer: scans run pipelined, each read issued in the cycle before its check.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    active_d    = active_q;
    qlimit_d    = qlimit_q;
    cnt_d       = cnt_q;
    chk_v_d     = 1'b0;
    chk_idx_d   = chk_idx_q;
    req_d       = req_q;
    ent_d       = ent_q;
    val_d       = val_q;
    best_d      = best_q;
    ties_d      = ties_q;
    seen_d      = seen_q;
    pick_d      = pick_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_we      = 1'b0;
    ram_waddr   = chk_idx_q;
    ram_wdata   = rdata;
    ram_re      = 1'b0;
    ram_raddr   = IDX_W'(cnt_q);
    div_start   = 1'b0;
    div_divisor = rdata.end_key;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d = in_data_i;
          cnt_d = '0;
          unique case (in_data_i.command) inside
            CMD_ADD: begin
              ent_d.end_key = in_data_i.key;
              ent_d.id      = in_data_i.dest_id;
              ent_d.dtype   = in_data_i.dest_type;
              ent_d.remote  = in_data_i.dest_remote;
              ent_d.qlen    = '0;
              state_d       = S_INS_CHK;
            end
            CMD_REMOVE, CMD_REKEY, CMD_BY_ID, CMD_SET_QLEN: begin
              state_d = S_FIND;
            end
            CMD_LOOKUP: begin
              if (count_q == '0) begin
                res_d   = res_err(ST_NONE, count_q);
                state_d = S_FIN;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = IDX_W'(count_q - CNT_W'(1));
                state_d   = S_LAST;
              end
            end
            CMD_SHORTEST: begin
              best_d  = qlimit_q;
              ties_d  = '0;
              state_d = S_SQ1;
            end
            CMD_BY_POS: begin
              if (CNT_W'(in_data_i.position) < count_q) begin
                ram_re    = 1'b1;
                ram_raddr = IDX_W'(in_data_i.position);
                state_d   = S_POS;
              end else begin
                res_d   = res_err(ST_NONE, count_q);
                state_d = S_FIN;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      // Lowest position whose id matches.
      S_FIND: begin
        if (cnt_q < count_q) begin
          ram_re    = 1'b1;
          cnt_d     = cnt_q + CNT_W'(1);
          chk_v_d   = 1'b1;
          chk_idx_d = IDX_W'(cnt_q);
        end
        if (chk_v_q && rdata.id == req_q.dest_id) begin
          chk_v_d = 1'b0;
          cnt_d   = CNT_W'(chk_idx_q) + CNT_W'(1);
          case (req_q.command)
            CMD_REMOVE: begin
              res_d   = res_ok(rdata, chk_idx_q, count_q - CNT_W'(1));
              state_d = S_SHIFT;
            end
            CMD_REKEY: begin
              ent_d         = rdata;
              ent_d.end_key = req_q.key;
              state_d       = S_SHIFT;
            end
            CMD_SET_QLEN: begin
              ram_we         = 1'b1;
              ram_waddr      = chk_idx_q;
              ram_wdata      = rdata;
              ram_wdata.qlen = req_q.queue_length;
              res_d          = res_ok(rdata, chk_idx_q, count_q);
              state_d        = S_FIN;
            end
            default: begin
              res_d   = res_ok(rdata, chk_idx_q, count_q);
              state_d = S_FIN;
            end
          endcase
        end else if (!chk_v_q && cnt_q >= count_q) begin
          res_d   = res_err(ST_NONE, count_q);
          state_d = S_FIN;
        end
      end

      // Close the gap: each entry above the removed one moves down by one.
      S_SHIFT: begin
        if (cnt_q < count_q) begin
          ram_re    = 1'b1;
          cnt_d     = cnt_q + CNT_W'(1);
          chk_v_d   = 1'b1;
          chk_idx_d = IDX_W'(cnt_q);
        end
        if (chk_v_q) begin
          ram_we    = 1'b1;
          ram_waddr = chk_idx_q - IDX_W'(1);
          ram_wdata = rdata;
        end else if (cnt_q >= count_q) begin
          count_d = count_q - CNT_W'(1);
          state_d = (req_q.command == CMD_REKEY) ? S_INS_CHK : S_FIN;
        end
      end

      // Type adoption comes before the checks, so it survives a rejection.
      S_INS_CHK: begin
        cnt_d = count_q;
        if (active_q == '0) begin
          active_d = ent_q.dtype;
        end
        if (req_q.key == '0) begin
          res_d   = res_err(ST_ZERO, count_q);
          state_d = S_FIN;
        end else if (ent_q.dtype != eff_type) begin
          res_d   = res_err(ST_TYPE, count_q);
          state_d = S_FIN;
        end else if (count_q >= CNT_W'(TABLE_DEPTH)) begin
          res_d   = res_err(ST_FULL, count_q);
          state_d = S_FIN;
        end else begin
          state_d = S_INS;
        end
      end

      // Walk down from the top, moving larger keys up until the slot is found.
      S_INS: begin
        if (cnt_q != '0) begin
          ram_re    = 1'b1;
          ram_raddr = IDX_W'(cnt_q - CNT_W'(1));
          cnt_d     = cnt_q - CNT_W'(1);
          chk_v_d   = 1'b1;
          chk_idx_d = IDX_W'(cnt_q - CNT_W'(1));
        end
        if (chk_v_q && ent_q.end_key < rdata.end_key) begin
          ram_we    = 1'b1;
          ram_waddr = chk_idx_q + IDX_W'(1);
          ram_wdata = rdata;
        end else if (chk_v_q || cnt_q == '0) begin
          ram_we    = 1'b1;
          ram_waddr = chk_v_q ? chk_idx_q + IDX_W'(1) : '0;
          ram_wdata = ent_q;
          count_d   = count_q + CNT_W'(1);
          res_d     = res_ok(ent_q, ram_waddr, count_q + CNT_W'(1));
          chk_v_d   = 1'b0;
          state_d   = S_FIN;
        end
      end

      // Last range end is in; reduce the key by it when it is nonzero.
      S_LAST: begin
        cnt_d = '0;
        if (rdata.end_key != '0) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end else begin
          val_d   = req_q.key;
          state_d = S_SCAN;
        end
      end

      S_DIV: begin
        div_divisor = KEY_W'(ties_q);
        cnt_d       = '0;
        if (div_done) begin
          if (req_q.command == CMD_LOOKUP) begin
            val_d   = div_rem;
            state_d = S_SCAN;
          end else begin
            pick_d  = CNT_W'(div_rem);
            seen_d  = '0;
            state_d = S_SQ2;
          end
        end
      end

      // First entry whose range end exceeds the reduced key.
      S_SCAN: begin
        if (cnt_q < count_q) begin
          ram_re    = 1'b1;
          cnt_d     = cnt_q + CNT_W'(1);
          chk_v_d   = 1'b1;
          chk_idx_d = IDX_W'(cnt_q);
        end
        if (chk_v_q && rdata.end_key > val_q) begin
          res_d   = res_ok(rdata, chk_idx_q, count_q);
          state_d = S_FIN;
        end else if (!chk_v_q && cnt_q >= count_q) begin
          res_d   = res_err(ST_NONE, count_q);
          state_d = S_FIN;
        end
      end

      // First pass: shortest local queue and how many share it.
      S_SQ1: begin
        if (cnt_q < count_q) begin
          ram_re    = 1'b1;
          cnt_d     = cnt_q + CNT_W'(1);
          chk_v_d   = 1'b1;
          chk_idx_d = IDX_W'(cnt_q);
        end
        if (chk_v_q) begin
          if (!rdata.remote && rdata.qlen < best_q) begin
            best_d = rdata.qlen;
            ties_d = CNT_W'(1);
          end else if (!rdata.remote && rdata.qlen == best_q) begin
            ties_d = ties_q + CNT_W'(1);
          end
        end else if (cnt_q >= count_q) begin
          if (ties_q == '0) begin
            res_d   = res_err(ST_NONE, count_q);
            state_d = S_FIN;
          end else begin
            div_start   = 1'b1;
            div_divisor = KEY_W'(ties_q);
            state_d     = S_DIV;
          end
        end
      end

      // Second pass: count through the tied entries to the chosen one.
      S_SQ2: begin
        if (cnt_q < count_q) begin
          ram_re    = 1'b1;
          cnt_d     = cnt_q + CNT_W'(1);
          chk_v_d   = 1'b1;
          chk_idx_d = IDX_W'(cnt_q);
        end
        if (chk_v_q && !rdata.remote && rdata.qlen == best_q) begin
          if (seen_q == pick_q) begin
            res_d   = res_ok(rdata, chk_idx_q, count_q);
            state_d = S_FIN;
          end else begin
            seen_d = seen_q + CNT_W'(1);
          end
        end else if (!chk_v_q && cnt_q >= count_q) begin
          res_d   = res_err(ST_NONE, count_q);
          state_d = S_FIN;
        end
      end

      S_POS: begin
        res_d   = res_ok(rdata, IDX_W'(req_q.position), count_q);
        state_d = S_FIN;
      end

      // Hand the result to the output register once it is free.
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Configuration writes; they must arrive only while the block is idle, which the user ensures, not the block.
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROUTE_TYPE:  active_d = cfg_wdata_i;
        CFG_QUEUE_LIMIT: qlimit_d = cfg_wdata_i;
        default:         active_d = active_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      active_q    <= '0;
      qlimit_q    <= '1;
      cnt_q       <= '0;
      chk_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      active_q    <= active_d;
      qlimit_q    <= qlimit_d;
      cnt_q       <= cnt_d;
      chk_v_q     <= chk_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q <= chk_idx_d;
    req_q     <= req_d;
    ent_q     <= ent_d;
    val_q     <= val_d;
    best_q    <= best_d;
    ties_q    <= ties_d;
    seen_q    <= seen_d;
    pick_q    <= pick_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `KR_ASSERT(a_count_bound, count_q <= CNT_W'(TABLE_DEPTH), "entry count beyond table depth")
  `KR_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready after accept")
  `KR_ASSERT(a_err_clean, (out_valid_o && out_data_o.status != ST_OK) |-> (out_data_o.found_id == '0 && out_data_o.found_end_key == '0 && out_data_o.found_position == '0), "error result carries entry data")
  `KR_ASSERT(a_count_step, (count_q == $past(count_q)) || (count_q == $past(count_q) + CNT_W'(1)) || (count_q + CNT_W'(1) == $past(count_q)), "entry count jumped")
  `KR_ASSERT_RST(a_reset_quiet, !rst_ni |=> !out_valid_o, "result valid in reset")

endmodule

// ===== verif/keyed_range_route_table_tb.sv =====
`timescale 1ns / 1ps

module keyed_range_route_table_tb;
  import kr_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  kr_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  kr_out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  keyed_range_route_table dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Mirror of the table contents and registers.
  logic [31:0] tbl_end [TABLE_DEPTH];
  logic [15:0] tbl_id [TABLE_DEPTH];
  logic [15:0] tbl_type [TABLE_DEPTH];
  logic        tbl_remote [TABLE_DEPTH];
  logic [15:0] tbl_qlen [TABLE_DEPTH];
  int unsigned tbl_count = 0;
  logic [15:0] cur_type = '0;
  logic [15:0] qlimit_reg = 16'hFFFF;

  kr_out_t pending_results[$];
  int errors = 0;
  int sent_total = 0;
  int got_total = 0;
  int full_seen = 0;

  // Fills a result from a table position, zeroing its entry fields on any error.
  function automatic kr_out_t entry_result(logic [2:0] st, int unsigned pos);
    kr_out_t r;
    r = '0;
    if (st == ST_OK && pos < tbl_count) begin
      r.status = ST_OK;
      r.found_id = tbl_id[pos];
      r.found_type = tbl_type[pos];
      r.found_remote = tbl_remote[pos];
      r.found_end_key = tbl_end[pos];
      r.found_position = pos[5:0];
    end else begin
      r.status = (st == ST_OK) ? ST_NONE : st;
    end
    r.entry_total = tbl_count[6:0];
    return r;
  endfunction

  function automatic int find_dest(logic [15:0] id);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void drop_entry(int unsigned idx);
    for (int unsigned i = idx; i + 1 < tbl_count; i++) begin
      tbl_end[i] = tbl_end[i+1];
      tbl_id[i] = tbl_id[i+1];
      tbl_type[i] = tbl_type[i+1];
      tbl_remote[i] = tbl_remote[i+1];
      tbl_qlen[i] = tbl_qlen[i+1];
    end
    tbl_count--;
  endfunction

  // Checked sorted insert after equal range ends.
  function automatic logic [2:0] place_entry(logic [31:0] key, logic [15:0] id,
      logic [15:0] dtype, logic remote, logic [15:0] qlen, output int unsigned pos);
    int unsigned i;
    pos = 0;
    if (cur_type == 16'd0) cur_type = dtype;
    if (key == 32'd0) return ST_ZERO;
    if (dtype != cur_type) return ST_TYPE;
    if (tbl_count >= TABLE_DEPTH) begin
      full_seen++;
      return ST_FULL;
    end
    for (i = tbl_count; i > 0 && key < tbl_end[i-1]; i--) begin
      tbl_end[i] = tbl_end[i-1];
      tbl_id[i] = tbl_id[i-1];
      tbl_type[i] = tbl_type[i-1];
      tbl_remote[i] = tbl_remote[i-1];
      tbl_qlen[i] = tbl_qlen[i-1];
    end
    tbl_end[i] = key;
    tbl_id[i] = id;
    tbl_type[i] = dtype;
    tbl_remote[i] = remote;
    tbl_qlen[i] = qlen;
    tbl_count++;
    pos = i;
    return ST_OK;
  endfunction

  // Applies one transaction to the mirror and returns its expected result.
  function automatic kr_out_t route_predict(kr_in_t t);
    kr_out_t r;
    int idx;
    int unsigned pos, i, best, ties, pick, seen;
    logic [31:0] last, v;
    logic [15:0] ty, q;
    logic rm;
    logic [2:0] st;
    pos = 0;
    case (t.command)
      CMD_ADD: begin
        st = place_entry(t.key, t.dest_id, t.dest_type, t.dest_remote, 16'd0, pos);
        r = entry_result(st, pos);
      end
      CMD_REMOVE: begin
        idx = find_dest(t.dest_id);
        if (idx < 0) return entry_result(ST_NONE, 0);
        r = entry_result(ST_OK, idx);
        drop_entry(idx);
        r.entry_total = tbl_count[6:0];
      end
      CMD_REKEY: begin
        idx = find_dest(t.dest_id);
        if (idx < 0) return entry_result(ST_NONE, 0);
        ty = tbl_type[idx];
        rm = tbl_remote[idx];
        q = tbl_qlen[idx];
        drop_entry(idx);
        st = place_entry(t.key, t.dest_id, ty, rm, q, pos);
        r = entry_result(st, pos);
      end
      CMD_LOOKUP: begin
        if (tbl_count == 0) return entry_result(ST_NONE, 0);
        last = tbl_end[tbl_count-1];
        v = (last != 0) ? t.key % last : t.key;
        for (i = 0; i < tbl_count; i++)
          if (tbl_end[i] > v) break;
        r = entry_result(i < tbl_count ? ST_OK : ST_NONE, i);
      end
      CMD_SHORTEST: begin
        best = qlimit_reg;
        ties = 0;
        seen = 0;
        for (i = 0; i < tbl_count; i++) begin
          if (tbl_remote[i]) continue;
          if (tbl_qlen[i] < best) begin
            best = tbl_qlen[i];
            ties = 1;
          end else if (tbl_qlen[i] == best) begin
            ties++;
          end
        end
        if (ties == 0) return entry_result(ST_NONE, 0);
        pick = t.key % ties;
        for (i = 0; i < tbl_count; i++) begin
          if (tbl_remote[i] || tbl_qlen[i] != best) continue;
          if (seen == pick) break;
          seen++;
        end
        r = entry_result(ST_OK, i);
      end
      CMD_BY_POS: r = entry_result(t.position < tbl_count ? ST_OK : ST_NONE, t.position);
      CMD_BY_ID: begin
        idx = find_dest(t.dest_id);
        r = entry_result(idx < 0 ? ST_NONE : ST_OK, idx < 0 ? 0 : idx);
      end
      default: begin
        idx = find_dest(t.dest_id);
        if (idx >= 0) tbl_qlen[idx] = t.queue_length;
        r = entry_result(idx < 0 ? ST_NONE : ST_OK, idx < 0 ? 0 : idx);
      end
    endcase
    return r;
  endfunction

  // Presents one transaction after a random gap and waits for acceptance.
  task automatic send_item(kr_in_t t, bit fixed, kr_out_t want);
    int gap;
    kr_out_t p;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i = t;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    p = route_predict(t);
    pending_results.push_back(fixed ? want : p);
    sent_total++;
    @(negedge clk_i);
  endtask

  // Drains outstanding results and writes one register.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_ROUTE_TYPE) begin
      cur_type = val;
    end else begin
      qlimit_reg = val;
    end
  endtask

  function automatic logic [31:0] pick_end_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 32'd0;
    if (r < 80) return $urandom_range(1, 1000);
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_dest_id();
    if (tbl_count != 0 && $urandom_range(0, 9) < 7)
      return tbl_id[$urandom_range(0, tbl_count - 1)];
    if ($urandom_range(0, 4) != 0) return 16'($urandom_range(0, 15));
    return 16'($urandom);
  endfunction

  // Random transaction; only adds when filling the table.
  function automatic kr_in_t random_item(bit fill);
    kr_in_t t;
    int r;
    t = '0;
    t.key = $urandom;
    t.dest_id = pick_dest_id();
    t.dest_remote = ($urandom_range(0, 3) == 0);
    t.position = 6'($urandom_range(0, 63));
    t.queue_length = ($urandom_range(0, 9) < 6) ? 16'($urandom_range(0, 4)) : 16'($urandom);
    if ($urandom_range(0, 19) != 0 && cur_type != 16'd0) t.dest_type = cur_type;
    else t.dest_type = 16'($urandom_range(1, 65535));
    r = fill ? 0 : $urandom_range(0, 99);
    if (r < 30) t.command = CMD_ADD;
    else if (r < 40) t.command = CMD_REMOVE;
    else if (r < 50) t.command = CMD_REKEY;
    else if (r < 65) t.command = CMD_LOOKUP;
    else if (r < 80) t.command = CMD_SHORTEST;
    else if (r < 87) t.command = CMD_BY_POS;
    else if (r < 93) t.command = CMD_BY_ID;
    else t.command = CMD_SET_QLEN;
    if (t.command == CMD_ADD || t.command == CMD_REKEY) begin
      t.key = pick_end_key();
      if (fill && t.key == 32'd0) t.key = 32'd7;
    end else if ($urandom_range(0, 1) == 0) begin
      t.key = $urandom_range(0, 2000);
    end
    return t;
  endfunction

  // Directed stimulus: fixed rows carry an expectation that is obvious.
  typedef struct {
    kr_in_t  stim;
    bit      fixed;
    kr_out_t want;
  } dir_row_t;

  function automatic dir_row_t mk(logic [2:0] cmd, logic [31:0] key, logic [15:0] id,
      logic [15:0] dtype, logic rm, logic [15:0] ql, logic [5:0] pos,
      bit fixed = 0, logic [2:0] st = ST_OK, logic [6:0] total = '0);
    dir_row_t d;
    d.stim = '{cmd, key, id, dtype, rm, ql, pos};
    d.fixed = fixed;
    d.want = '0;
    d.want.status = st;
    d.want.entry_total = total;
    return d;
  endfunction

  dir_row_t dir_rows[$];

  initial begin
    dir_rows = '{
      mk(CMD_LOOKUP, 32'd5, 16'd0, 16'd1, 1'b0, 16'd0, 6'd0, 1, ST_NONE, 7'd0),
      mk(CMD_SHORTEST, 32'd9, 16'd0, 16'd1, 1'b0, 16'd0, 6'd0, 1, ST_NONE, 7'd0),
      mk(CMD_BY_POS, 32'd0, 16'd0, 16'd1, 1'b0, 16'd0, 6'd0, 1, ST_NONE, 7'd0),
      mk(CMD_ADD, 32'd0, 16'd1, 16'd7, 1'b0, 16'd0, 6'd0, 1, ST_ZERO, 7'd0),
      mk(CMD_ADD, 32'd10, 16'd1, 16'd8, 1'b0, 16'd0, 6'd0, 1, ST_TYPE, 7'd0),
      mk(CMD_ADD, 32'hFFFF_FFFF, 16'hFFFF, 16'd7, 1'b1, 16'hFFFF, 6'h3F),
      mk(CMD_ADD, 32'd1, 16'd0, 16'd7, 1'b0, 16'd0, 6'd0),
      mk(CMD_ADD, 32'd10, 16'd2, 16'd7, 1'b0, 16'd0, 6'd0),
      mk(CMD_ADD, 32'd10, 16'd3, 16'd7, 1'b0, 16'd0, 6'd0),
      mk(CMD_ADD, 32'h8000_0000, 16'd2, 16'd7, 1'b0, 16'd0, 6'd0),
      mk(CMD_BY_ID, 32'd0, 16'd2, 16'd1, 1'b0, 16'd0, 6'd0),
      mk(CMD_SET_QLEN, 32'd0, 16'd3, 16'd1, 1'b0, 16'hFFFF, 6'd0),
      mk(CMD_SET_QLEN, 32'd0, 16'd0, 16'd1, 1'b0, 16'd0, 6'd0),
      mk(CMD_SHORTEST, 32'hFFFF_FFFF, 16'd0, 16'd1, 1'b0, 16'd0, 6'd0),
      mk(CMD_LOOKUP, 32'hFFFF_FFFF, 16'd0, 16'd1, 1'b0, 16'd0, 6'd0),
      mk(CMD_LOOKUP, 32'd0, 16'd0, 16'd1, 1'b0, 16'd0, 6'd0),
      mk(CMD_BY_POS, 32'd0, 16'd0, 16'd1, 1'b0, 16'd0, 6'h3F, 1, ST_NONE, 7'd5),
      mk(CMD_BY_POS, 32'd0, 16'd0, 16'd1, 1'b0, 16'd0, 6'd4),
      mk(CMD_REKEY, 32'd5, 16'd2, 16'd1, 1'b0, 16'd0, 6'd0),
      mk(CMD_REKEY, 32'd0, 16'd3, 16'd1, 1'b0, 16'd0, 6'd0, 1, ST_ZERO, 7'd4),
      mk(CMD_REKEY, 32'd9, 16'd999, 16'd1, 1'b0, 16'd0, 6'd0, 1, ST_NONE, 7'd4),
      mk(CMD_REMOVE, 32'd0, 16'hFFFF, 16'd1, 1'b0, 16'd0, 6'd0),
      mk(CMD_REMOVE, 32'd0, 16'h1234, 16'd1, 1'b0, 16'd0, 6'd0, 1, ST_NONE, 7'd3),
      mk(CMD_BY_ID, 32'd0, 16'd0, 16'd1, 1'b0, 16'd0, 6'h2A),
      mk(CMD_BY_POS, 32'h5555_AAAA, 16'h5A5A, 16'hA5A5, 1'b1, 16'h5A5A, 6'd2)
    };
  end

  // Result side: random stalls, each transaction checked in order.
  initial begin
    int stall;
    kr_out_t exp_r;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      got_total++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data_o);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data_o.status !== exp_r.status ||
            out_data_o.found_id !== exp_r.found_id ||
            out_data_o.found_type !== exp_r.found_type ||
            out_data_o.found_remote !== exp_r.found_remote ||
            out_data_o.found_end_key !== exp_r.found_end_key ||
            out_data_o.found_position !== exp_r.found_position ||
            out_data_o.entry_total !== exp_r.entry_total) begin
          $display("%0t: mismatch expected %p actual %p", $time, exp_r, out_data_o);
          errors++;
        end
      end
    end
  end

  // Transaction side: directed rows, then random phases at several settings.
  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (dir_rows[i]) send_item(dir_rows[i].stim, dir_rows[i].fixed, dir_rows[i].want);
    repeat (250) send_item(random_item(0), 0, '0);
    write_reg(CFG_ROUTE_TYPE, 16'd5);
    write_reg(CFG_QUEUE_LIMIT, 16'd3);
    repeat (200) send_item(random_item(0), 0, '0);
    write_reg(CFG_ROUTE_TYPE, 16'hFFFF);
    write_reg(CFG_QUEUE_LIMIT, 16'd0);
    repeat (70) send_item(random_item(1), 0, '0);
    repeat (150) send_item(random_item(0), 0, '0);
    write_reg(CFG_ROUTE_TYPE, 16'd0);
    write_reg(CFG_QUEUE_LIMIT, 16'hFFFF);
    repeat (150) send_item(random_item(0), 0, '0);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
    $display("Sent %0d transactions and checked %0d results across four register settings.",
             sent_total, got_total);
    $display("Full-table rejections seen: %0d.", full_seen);
    if (errors == 0) begin
      $display("keyed_range_route_table_tb: PASS");
    end else begin
      $display("keyed_range_route_table_tb: FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #20ms;
    $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
    $display("keyed_range_route_table_tb: FAIL");
    $finish;
  end

endmodule

// ===== keyed_range_route_table.f =====
+incdir+rtl
rtl/kr_pkg.sv
rtl/kr_ram.sv
rtl/kr_div.sv
rtl/keyed_range_route_table.sv
verif/keyed_range_route_table_tb.sv
